>>> rtl/sipq_pkg.sv
// ----------------------------------------------------------------------------
// sipq_pkg
// Shared types and constants for the software-interrupt priority queue.
// ----------------------------------------------------------------------------
package sipq_pkg;

    localparam int NUM_IDS     = 64;
    localparam int ID_W        = 6;
    localparam int NUM_LEVELS  = 5;
    localparam int LEVEL_W     = 3;
    localparam int PRI_W       = 8;
    localparam int PRI_BIAS    = 32;
    localparam int LEVEL_SHIFT = 4;
    localparam int STATUS_W    = 3;

    typedef enum logic {
        REQ_CAUSE    = 1'b0,
        REQ_DISPATCH = 1'b1
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_QUEUED     = 3'd0,
        STAT_DUP        = 3'd1,
        STAT_BAD        = 3'd2,
        STAT_DISPATCHED = 3'd3,
        STAT_NONE       = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP
    } state_t;

    typedef struct packed {
        logic load_req;
        logic do_cause;
        logic issue_read;
        logic do_pop;
        logic load_none;
    } sipq_cmd_t;

    typedef struct packed {
        req_t req_type;
        logic pending;
        logic out_free;
    } sipq_sts_t;

endpackage

>>> rtl/soft_interrupt_priority_queue_top.sv
// ----------------------------------------------------------------------------
// soft_interrupt_priority_queue_top
// Software-interrupt queue with five priority levels, one linked FIFO each.
// ----------------------------------------------------------------------------
// A cause request is accepted, then executed; a dispatch that finds a pending
// id also needs the registered read of the next-link memory before the
// level head advances, held in link_rd_reg. One request is in
// flight at a time; the result sits in an output register, so the next
// request is accepted as soon as that result is loaded, and the block stalls
// only when a new result is ready while the previous one is still untaken.
module soft_interrupt_priority_queue_top import sipq_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_req_type,
    input  logic [ID_W-1:0]         s_int_id,
    input  logic signed [PRI_W-1:0] s_priority_req,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [STATUS_W-1:0]     m_status,
    output logic [ID_W-1:0]         m_out_id,
    output logic [LEVEL_W-1:0]      m_out_level,
    output logic                    m_any_pending
);

    sipq_cmd_t cmd;
    sipq_sts_t sts;

    sipq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sipq_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_req_type     (s_req_type),
        .s_int_id       (s_int_id),
        .s_priority_req (s_priority_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_id       (m_out_id),
        .m_out_level    (m_out_level),
        .m_any_pending  (m_any_pending)
    );

endmodule

>>> rtl/sipq_ctrl.sv
// ----------------------------------------------------------------------------
// sipq_ctrl
// Request sequencer: accept, execute, and for a dispatch the link-read step.
// ----------------------------------------------------------------------------
module sipq_ctrl import sipq_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  sipq_sts_t sts,
    output sipq_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.req_type == REQ_CAUSE || !sts.pending) begin
                    if (sts.out_free) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_req = s_valid;
            end
            ST_EXEC: begin
                if (sts.req_type == REQ_CAUSE) begin
                    cmd.do_cause = sts.out_free;
                end else if (!sts.pending) begin
                    cmd.load_none = sts.out_free;
                end else begin
                    cmd.issue_read = 1'b1;
                end
            end
            ST_POP: begin
                cmd.do_pop = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/sipq_dpath.sv
// ----------------------------------------------------------------------------
// sipq_dpath
// Level lists (head, tail, non-empty), queued marks, next-link memory and
// the result register.
// ----------------------------------------------------------------------------
module sipq_dpath import sipq_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sipq_cmd_t                  cmd,
    output sipq_sts_t                  sts,
    input  logic                       s_req_type,
    input  logic [ID_W-1:0]            s_int_id,
    input  logic signed [PRI_W-1:0]    s_priority_req,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic [ID_W-1:0]            m_out_id,
    output logic [LEVEL_W-1:0]         m_out_level,
    output logic                       m_any_pending
);

    req_t                    req_type_reg;
    logic [ID_W-1:0]         int_id_reg;
    logic signed [PRI_W-1:0] priority_reg;

    logic [NUM_IDS-1:0]      queued_mark_reg;
    logic [ID_W-1:0]         level_head_reg [NUM_LEVELS];
    logic [ID_W-1:0]         level_tail_reg [NUM_LEVELS];
    logic [NUM_LEVELS-1:0]   level_nonempty_reg;

    logic [ID_W-1:0]         next_link_mem [NUM_IDS];
    logic [ID_W-1:0]         link_rd_reg;

    logic                    m_valid_reg;
    status_t                 status_reg;
    logic [ID_W-1:0]         out_id_reg;
    logic [LEVEL_W-1:0]      out_level_reg;
    logic                    any_pending_reg;

    logic signed [PRI_W:0]   pri_biased;
    logic                    pri_ok;
    logic                    id_ok;
    logic                    is_dup;
    logic [LEVEL_W-1:0]      cause_lvl;
    logic [LEVEL_W-1:0]      top_lvl;
    logic [ID_W-1:0]         top_head;
    logic                    top_last;
    logic                    out_free;

    assign pri_biased = {priority_reg[PRI_W-1], priority_reg} + (PRI_W+1)'(PRI_BIAS);
    assign pri_ok     = !pri_biased[PRI_W]
                        && (pri_biased < (PRI_W+1)'(NUM_LEVELS << LEVEL_SHIFT));
    assign cause_lvl  = LEVEL_W'(pri_biased[PRI_W-1:0] >> LEVEL_SHIFT);
    assign id_ok      = ({1'b0, int_id_reg} < (ID_W+1)'(NUM_IDS));
    assign is_dup     = queued_mark_reg[int_id_reg];

    always_comb begin
        top_lvl = '0;
        for (int k = 0; k < NUM_LEVELS; k++) begin
            if (level_nonempty_reg[k]) begin
                top_lvl = LEVEL_W'(k);
            end
        end
    end

    assign top_head = level_head_reg[top_lvl];
    assign top_last = (top_head == level_tail_reg[top_lvl]);
    assign out_free = !m_valid_reg || m_ready;

    assign sts.req_type = req_type_reg;
    assign sts.pending  = |level_nonempty_reg;
    assign sts.out_free = out_free;

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_type_reg <= req_t'(s_req_type);
            int_id_reg   <= s_int_id;
            priority_reg <= s_priority_req;
        end
    end

    // next-link memory
    always_ff @(posedge aclk) begin
        if (cmd.do_cause && id_ok && !is_dup && pri_ok
            && level_nonempty_reg[cause_lvl]) begin
            next_link_mem[level_tail_reg[cause_lvl]] <= int_id_reg;
        end
        if (cmd.issue_read) begin
            link_rd_reg <= next_link_mem[top_head];
        end
    end

    // list state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queued_mark_reg    <= '0;
            level_nonempty_reg <= '0;
            for (int k = 0; k < NUM_LEVELS; k++) begin
                level_head_reg[k] <= '0;
                level_tail_reg[k] <= '0;
            end
        end else if (cmd.do_cause && id_ok && !is_dup && pri_ok) begin
            if (!level_nonempty_reg[cause_lvl]) begin
                level_head_reg[cause_lvl]     <= int_id_reg;
                level_nonempty_reg[cause_lvl] <= 1'b1;
            end
            level_tail_reg[cause_lvl]   <= int_id_reg;
            queued_mark_reg[int_id_reg] <= 1'b1;
        end else if (cmd.do_pop) begin
            if (top_last) begin
                level_nonempty_reg[top_lvl] <= 1'b0;
            end else begin
                level_head_reg[top_lvl] <= link_rd_reg;
            end
            queued_mark_reg[top_head] <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.do_cause || cmd.do_pop || cmd.load_none) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_cause) begin
            out_id_reg <= '0;
            if (!id_ok) begin
                status_reg      <= STAT_BAD;
                out_level_reg   <= '0;
                any_pending_reg <= |level_nonempty_reg;
            end else if (is_dup) begin
                status_reg      <= STAT_DUP;
                out_level_reg   <= '0;
                any_pending_reg <= |level_nonempty_reg;
            end else if (!pri_ok) begin
                status_reg      <= STAT_BAD;
                out_level_reg   <= '0;
                any_pending_reg <= |level_nonempty_reg;
            end else begin
                status_reg      <= STAT_QUEUED;
                out_level_reg   <= cause_lvl;
                any_pending_reg <= 1'b1;
            end
        end else if (cmd.do_pop) begin
            status_reg      <= STAT_DISPATCHED;
            out_id_reg      <= top_head;
            out_level_reg   <= top_lvl;
            any_pending_reg <= !top_last || (level_nonempty_reg != (NUM_LEVELS'(1) << top_lvl));
        end else if (cmd.load_none) begin
            status_reg      <= STAT_NONE;
            out_id_reg      <= '0;
            out_level_reg   <= '0;
            any_pending_reg <= 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_out_id      = out_id_reg;
    assign m_out_level   = out_level_reg;
    assign m_any_pending = any_pending_reg;

endmodule
